>>> rtl/core/qmn_pkg.sv
// shared types and fixed widths for the normalized quaternion product
package qmn_pkg;

	localparam int QW = 31;
	localparam int RADW = 64;
	localparam int RW = 32;

	typedef struct packed {
		logic [3:0]         neg;
		logic               zero;
	} qmn_tag_t;

	typedef struct packed {
		logic [3:0][QW-1:0] q;
		qmn_tag_t           tag;
	} qmn_side_t;

	typedef struct packed {
		logic en;
		logic vld;
	} qmn_ctl_t;

endpackage

>>> rtl/core/quaternion_multiply_normalize.sv
// normalized hamilton product of two fixed-point quaternions
// Usage: one input channel (in_valid/in_ready) carries quaternions a and b as
// signed fixed-point components with FRACTION_BITS fraction bits; one output
// channel (out_valid/out_ready) returns the unit-length product and zero_norm.
// Every transfer in gives exactly one transfer out, in order.
// The pipeline runs seven stages of multiply, sum, magnitude, leading-one
// search, shift, square and sum, then 32 square-root stages, FRACTION_BITS + 2
// divider stages and the output register. Throughput is one item per cycle
// while the output is not stalled; no state is kept between items.
// A zero product gives all-zero components with zero_norm set.
// Reset empties the pipeline: all valid bits clear, out_valid goes low and
// in_ready is high. When the receiver holds out_ready low with a result
// waiting, the whole pipeline freezes and in_ready drops; nothing is lost or
// repeated, and the pipeline moves again in the cycle out_ready returns.
module quaternion_multiply_normalize
	import qmn_pkg::*;
#(
	parameter int COMPONENT_WIDTH = 16,
	parameter int FRACTION_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COMPONENT_WIDTH-1:0] a_w,
	input  logic signed [COMPONENT_WIDTH-1:0] a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] b_w,
	input  logic signed [COMPONENT_WIDTH-1:0] b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] b_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COMPONENT_WIDTH-1:0] prod_w,
	output logic signed [COMPONENT_WIDTH-1:0] prod_x,
	output logic signed [COMPONENT_WIDTH-1:0] prod_y,
	output logic signed [COMPONENT_WIDTH-1:0] prod_z,
	output logic                              zero_norm
);

	localparam int CW  = COMPONENT_WIDTH;
	localparam int FB  = FRACTION_BITS;
	localparam int QB  = FB + 1;
	localparam int PW  = 2 * CW + 2;
	localparam int BLW = $clog2(PW + 1);
	localparam int OW  = ((QB + 1 > CW) ? QB + 1 : CW) + 1;
	localparam logic signed [OW-1:0] HI_LIM = OW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [OW-1:0] LO_LIM = -HI_LIM - OW'(1);

	logic     en;
	qmn_ctl_t ctl_in;
	qmn_ctl_t ctl_sq;
	qmn_ctl_t ctl_dv;

	logic signed [CW-1:0] av [4];
	logic signed [CW-1:0] bv [4];

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [2*CW-1:0] prod_s1 [4][4];
	logic signed [PW-1:0]   p_s2 [4];
	logic [PW-1:0]          mag_s3 [4];
	logic [3:0]             neg_s3;
	logic [PW-1:0]          mag_s4 [4];
	logic [3:0]             neg_s4;
	logic [BLW-1:0]         len_s4;
	logic [3:0][QW-1:0]     q_s5;
	qmn_tag_t               tag_s5;
	logic [2*QW-1:0]        sq_s6 [4];
	logic [3:0][QW-1:0]     q_s6;
	qmn_tag_t               tag_s6;
	logic [RADW-1:0]        sum_s7;
	qmn_side_t              side_s7;

	logic                   sq_valid;
	logic [RW-1:0]          sq_root;
	qmn_side_t              sq_side;
	logic                   dv_valid;
	logic [3:0][FB:0]       dv_quo;
	qmn_tag_t               dv_tag;

	logic                   out_valid_q;
	logic [3:0][CW-1:0]     res_q;
	logic                   zero_q;

	// one shared advance for every stage: move unless a result is stuck
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	assign av[0] = a_w;
	assign av[1] = a_x;
	assign av[2] = a_y;
	assign av[3] = a_z;
	assign bv[0] = b_w;
	assign bv[1] = b_x;
	assign bv[2] = b_y;
	assign bv[3] = b_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic [PW-1:0]      orv;
		logic [PW+QW-1:0]   wide;
		logic [BLW-1:0]     len;
		if (en) begin
			// sixteen partial products
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= av[i] * bv[j];
				end
			end

			// hamilton sums at full width
			p_s2[0] <= PW'(prod_s1[0][0]) - PW'(prod_s1[1][1])
				- PW'(prod_s1[2][2]) - PW'(prod_s1[3][3]);
			p_s2[1] <= PW'(prod_s1[0][1]) + PW'(prod_s1[1][0])
				+ PW'(prod_s1[2][3]) - PW'(prod_s1[3][2]);
			p_s2[2] <= PW'(prod_s1[0][2]) - PW'(prod_s1[1][3])
				+ PW'(prod_s1[2][0]) + PW'(prod_s1[3][1]);
			p_s2[3] <= PW'(prod_s1[0][3]) + PW'(prod_s1[1][2])
				- PW'(prod_s1[2][1]) + PW'(prod_s1[3][0]);

			for (int i = 0; i < 4; i++) begin
				neg_s3[i] <= p_s2[i][PW-1];
				mag_s3[i] <= p_s2[i][PW-1] ? PW'(-p_s2[i]) : PW'(p_s2[i]);
			end

			// bit length of the largest magnitude equals that of the or
			orv = mag_s3[0] | mag_s3[1] | mag_s3[2] | mag_s3[3];
			len = '0;
			for (int b = 0; b < PW; b++) begin
				if (orv[b]) begin
					len = BLW'(b + 1);
				end
			end
			len_s4 <= len;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;

			// shared shift puts the top bit at position 30
			for (int i = 0; i < 4; i++) begin
				wide = {mag_s4[i], {QW{1'b0}}} >> len_s4;
				q_s5[i] <= wide[QW-1:0];
			end
			tag_s5.neg  <= neg_s4;
			tag_s5.zero <= (len_s4 == '0);

			for (int i = 0; i < 4; i++) begin
				sq_s6[i] <= q_s5[i] * q_s5[i];
			end
			q_s6   <= q_s5;
			tag_s6 <= tag_s5;

			sum_s7 <= RADW'(sq_s6[0]) + RADW'(sq_s6[1])
				+ RADW'(sq_s6[2]) + RADW'(sq_s6[3]);
			side_s7.q   <= q_s6;
			side_s7.tag <= tag_s6;
		end
	end

	assign ctl_in.en  = en;
	assign ctl_in.vld = vld_s7;

	qmn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_in),
		.rad      (sum_s7),
		.side_in  (side_s7),
		.out_valid(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	assign ctl_sq.en  = en;
	assign ctl_sq.vld = sq_valid;

	qmn_div #(
		.FB(FB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_sq),
		.divisor  (sq_root),
		.q        (sq_side.q),
		.tag_in   (sq_side.tag),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.tag_out  (dv_tag)
	);

	assign ctl_dv.en  = en;
	assign ctl_dv.vld = dv_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_dv.en) begin
			out_valid_q <= ctl_dv.vld;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [OW-1:0] mv;
		logic signed [OW-1:0] v;
		if (ctl_dv.en) begin
			for (int i = 0; i < 4; i++) begin
				mv = signed'(OW'(dv_quo[i]));
				v  = dv_tag.neg[i] ? -mv : mv;
				if (dv_tag.zero) begin
					res_q[i] <= '0;
				end else if (v > HI_LIM) begin
					res_q[i] <= HI_LIM[CW-1:0];
				end else if (v < LO_LIM) begin
					res_q[i] <= LO_LIM[CW-1:0];
				end else begin
					res_q[i] <= v[CW-1:0];
				end
			end
			zero_q <= dv_tag.zero;
		end
	end

	assign out_valid = out_valid_q;
	assign prod_w    = res_q[0];
	assign prod_x    = res_q[1];
	assign prod_y    = res_q[2];
	assign prod_z    = res_q[3];
	assign zero_norm = zero_q;

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> prod_w == '0 && prod_x == '0
			&& prod_y == '0 && prod_z == '0)
		else $error("zero norm result with nonzero components");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted transfer did not enter the pipeline");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv_tag.zero |->
			dv_quo[0] <= (QB)'(1) << FB && dv_quo[1] <= (QB)'(1) << FB
			&& dv_quo[2] <= (QB)'(1) << FB && dv_quo[3] <= (QB)'(1) << FB)
		else $error("normalized magnitude above one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s7) && $stable(sq_valid))
		else $error("pipeline moved during a stall");

endmodule

>>> rtl/core/qmn_isqrt.sv
// pipelined integer square root, one root bit per stage
module qmn_isqrt
	import qmn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  qmn_ctl_t          ctl,
	input  logic [RADW-1:0]   rad,
	input  qmn_side_t         side_in,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output qmn_side_t         side_out
);

	logic [RW-1:0]   vld_q;
	logic [RW+2:0]   rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [RADW-1:0] rad_q  [RW];
	qmn_side_t       side_q [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic            v_i;
		logic [RW+2:0]   rem_i;
		logic [RW-1:0]   root_i;
		logic [RADW-1:0] rad_i;
		qmn_side_t       side_i;
		logic [RW+2:0]   acc;
		logic [RW+2:0]   trial;

		if (g == 0) begin : g_first
			assign v_i    = ctl.vld;
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = vld_q[g-1];
			assign rem_i  = rem_q[g-1];
			assign root_i = root_q[g-1];
			assign rad_i  = rad_q[g-1];
			assign side_i = side_q[g-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign acc   = {rem_i[RW:0], rad_i[RADW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (ctl.en) begin
				vld_q[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (acc >= trial) begin
					rem_q[g]  <= acc - trial;
					root_q[g] <= {root_i[RW-2:0], 1'b1};
				end else begin
					rem_q[g]  <= acc;
					root_q[g] <= {root_i[RW-2:0], 1'b0};
				end
				rad_q[g]  <= {rad_i[RADW-3:0], 2'b00};
				side_q[g] <= side_i;
			end
		end
	end

	assign out_valid = vld_q[RW-1];
	assign root      = root_q[RW-1];
	assign side_out  = side_q[RW-1];

endmodule

>>> rtl/core/qmn_div.sv
// pipelined restoring divider, four lanes sharing one divisor
module qmn_div
	import qmn_pkg::*;
#(
	parameter int FB = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qmn_ctl_t             ctl,
	input  logic [RW-1:0]        divisor,
	input  logic [3:0][QW-1:0]   q,
	input  qmn_tag_t             tag_in,
	output logic                 out_valid,
	output logic [3:0][FB:0]     quo,
	output qmn_tag_t             tag_out
);

	localparam int QB = FB + 1;
	localparam int DW = QW + FB + 1;

	logic [QB:0]           vld_q;
	logic [3:0][RW:0]      rem_q  [QB+1];
	logic [3:0][QB-1:0]    low_q  [QB+1];
	logic [3:0][QB-1:0]    quo_q  [QB+1];
	logic [RW-1:0]         dvs_q  [QB+1];
	qmn_tag_t              tag_q  [QB+1];

	// first stage: dividend with half divisor added for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (ctl.en) begin
			vld_q[0] <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		logic [DW-1:0] dvd;
		if (ctl.en) begin
			for (int l = 0; l < 4; l++) begin
				dvd = (DW'(q[l]) << FB) + DW'(divisor >> 1);
				rem_q[0][l] <= (RW+1)'(dvd >> QB);
				low_q[0][l] <= dvd[QB-1:0];
				quo_q[0][l] <= '0;
			end
			dvs_q[0] <= divisor;
			tag_q[0] <= tag_in;
		end
	end

	for (genvar g = 1; g <= QB; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (ctl.en) begin
				vld_q[g] <= vld_q[g-1];
			end
		end

		always_ff @(posedge clk) begin
			logic [RW:0] acc;
			if (ctl.en) begin
				for (int l = 0; l < 4; l++) begin
					acc = {rem_q[g-1][l][RW-1:0], low_q[g-1][l][QB-1]};
					if (acc >= {1'b0, dvs_q[g-1]}) begin
						rem_q[g][l] <= acc - {1'b0, dvs_q[g-1]};
						quo_q[g][l] <= {quo_q[g-1][l][QB-2:0], 1'b1};
					end else begin
						rem_q[g][l] <= acc;
						quo_q[g][l] <= {quo_q[g-1][l][QB-2:0], 1'b0};
					end
					low_q[g][l] <= {low_q[g-1][l][QB-2:0], 1'b0};
				end
				dvs_q[g] <= dvs_q[g-1];
				tag_q[g] <= tag_q[g-1];
			end
		end
	end

	assign out_valid = vld_q[QB];
	assign quo       = quo_q[QB];
	assign tag_out   = tag_q[QB];

endmodule
